// ----- sv/mpi_pkg.sv -----
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared types and constants of the map position interpolator.
// ----------------------------------------------------------------------------
package mpi_pkg;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_DEGEN  = 2'd2;

    localparam logic [23:0] WINDOW_RESET = 24'd327680;

    typedef struct packed {
        logic [1:0]         mode;
        logic [30:0]        phys_pos;
        logic signed [31:0] map_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] gen_pos;
        logic [1:0]         status;
    } res_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PSRCH,
        ST_PCMP,
        ST_HRD,
        ST_HCHK,
        ST_KEY,
        ST_MSRCH,
        ST_MCMP,
        ST_RDA,
        ST_RDB,
        ST_CALC,
        ST_MUL0,
        ST_MUL1,
        ST_DGO,
        ST_DWAIT
    } back_state_t;

endpackage

// ----- sv/mpi_ram.sv -----
// ----------------------------------------------------------------------------
// mpi_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module mpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/mpi_div.sv -----
// ----------------------------------------------------------------------------
// mpi_div
// Restoring unsigned divider, 64-bit dividend by 31-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module mpi_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [63:0] quot
);

    logic [63:0] dvd_reg, dvd_next;
    logic [30:0] rem_reg, rem_next;
    logic [30:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [31:0] rem_sh;
    logic [31:0] diff;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, dvd_reg[63]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            dvd_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = diff[30:0];
                dvd_next = {dvd_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[30:0];
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

// ----- sv/mpi_front.sv -----
// ----------------------------------------------------------------------------
// mpi_front
// Command intake: two-entry queue in front of the execution sequencer.
// ----------------------------------------------------------------------------
module mpi_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mpi_pkg::cmd_t cmd,
    output logic          busy,
    output mpi_pkg::qhead_t head,
    input  logic          pop
);

    mpi_pkg::cmd_t slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign head = {(cnt_reg != 2'd0), slot_reg[rptr_reg]};

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= cmd;
        end
    end

endmodule

// ----- sv/mpi_back.sv -----
// ----------------------------------------------------------------------------
// mpi_back
// Execution sequencer: table writes, both binary searches, interpolation.
// ----------------------------------------------------------------------------
module mpi_back #(
    parameter int MAP_DEPTH = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [23:0]     end_window,
    input  mpi_pkg::qhead_t head,
    output logic            pop,
    output mpi_pkg::res_t   result,
    output logic            result_valid
);

    localparam int CW = $clog2(MAP_DEPTH + 1);
    localparam int AW = $clog2(MAP_DEPTH);

    mpi_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        first_reg, first_next;
    logic [CW-1:0]        len_reg, len_next;
    logic [30:0]          site_reg, site_next;
    logic signed [33:0]   key_reg, key_next;
    logic                 right_reg, right_next;
    logic [AW-1:0]        ia_reg, ia_next;
    logic [AW-1:0]        ib_reg, ib_next;
    logic [30:0]          a_reg, a_next;
    logic signed [31:0]   fa_reg, fa_next;
    logic [30:0]          dx_reg, dx_next;
    logic [31:0]          dy_reg, dy_next;
    logic [30:0]          db_reg, db_next;
    logic                 neg_reg, neg_next;
    logic [63:0]          prod_reg, prod_next;
    mpi_pkg::res_t        res_reg, res_next;
    logic                 rv_reg, rv_next;

    logic                 we;
    logic [AW-1:0]        raddr;
    logic [30:0]          rd_phys;
    logic [31:0]          rd_map;
    logic                 div_start;
    logic                 div_done;
    logic [63:0]          quot;

    logic [CW-1:0]        half;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        last;
    logic signed [33:0]   rd_map_x;
    logic [31:0]          dx_s;
    logic [31:0]          db_s;
    logic [32:0]          dy_s;
    logic [31:0]          dx_neg;
    logic [31:0]          db_neg;
    logic [32:0]          dy_neg;
    logic [46:0]          p0;
    logic [46:0]          p1;
    logic [40:0]          qmag;
    logic signed [41:0]   qs;
    logic signed [41:0]   sum;

    assign half     = len_reg >> 1;
    assign mid      = first_reg + half;
    assign last     = count_reg - CW'(1);
    assign rd_map_x = {{2{rd_map[31]}}, rd_map};
    assign dx_s     = {1'b0, site_reg} - {1'b0, a_reg};
    assign db_s     = {1'b0, rd_phys} - {1'b0, a_reg};
    assign dy_s     = {rd_map[31], rd_map} - {fa_reg[31], fa_reg};
    assign dx_neg   = -dx_s;
    assign db_neg   = -db_s;
    assign dy_neg   = -dy_s;
    assign p0       = 47'(dx_reg) * 47'(dy_reg[15:0]);
    assign p1       = 47'(dx_reg) * 47'(dy_reg[31:16]);
    assign qmag     = (quot > 64'(41'h100_0000_0000)) ? 41'h100_0000_0000 : quot[40:0];
    assign qs       = neg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
    assign sum      = {{10{fa_reg[31]}}, fa_reg} + qs;

    mpi_ram #(.WIDTH(31), .DEPTH(MAP_DEPTH)) u_phys_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (head.cmd.phys_pos),
        .raddr (raddr),
        .rdata (rd_phys)
    );

    mpi_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (head.cmd.map_value),
        .raddr (raddr),
        .rdata (rd_map)
    );

    mpi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (db_reg),
        .done     (div_done),
        .quot     (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        first_next = first_reg;
        len_next   = len_reg;
        site_next  = site_reg;
        key_next   = key_reg;
        right_next = right_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        a_next     = a_reg;
        fa_next    = fa_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        db_next    = db_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        rv_next    = 1'b0;
        we         = 1'b0;
        pop        = 1'b0;
        div_start  = 1'b0;
        raddr      = mid[AW-1:0];
        unique case (state_reg)
            mpi_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    site_next = head.cmd.phys_pos;
                    unique case (head.cmd.mode)
                        mpi_pkg::MODE_APPEND:
                        begin
                            if (count_reg < CW'(MAP_DEPTH))
                            begin
                                we = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        mpi_pkg::MODE_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.gen_pos = '0;
                                res_next.status  = mpi_pkg::STATUS_EMPTY;
                                rv_next = 1'b1;
                            end
                            else
                            begin
                                first_next = '0;
                                len_next   = count_reg;
                                state_next = mpi_pkg::ST_PSRCH;
                            end
                        end
                        mpi_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mpi_pkg::ST_PSRCH:
            begin
                state_next = (len_reg == '0) ? mpi_pkg::ST_HRD : mpi_pkg::ST_PCMP;
            end
            mpi_pkg::ST_PCMP:
            begin
                if (rd_phys < site_reg)
                begin
                    first_next = mid + CW'(1);
                    len_next   = len_reg - half - CW'(1);
                end
                else
                begin
                    len_next = half;
                end
                state_next = mpi_pkg::ST_PSRCH;
            end
            mpi_pkg::ST_HRD:
            begin
                if (first_reg < count_reg)
                begin
                    raddr = first_reg[AW-1:0];
                    state_next = mpi_pkg::ST_HCHK;
                end
                else
                begin
                    // past the last entry: key from the last map value
                    raddr = last[AW-1:0];
                    state_next = mpi_pkg::ST_KEY;
                end
            end
            mpi_pkg::ST_HCHK:
            begin
                if (rd_phys == site_reg)
                begin
                    res_next.gen_pos = rd_map;
                    res_next.status  = mpi_pkg::STATUS_OK;
                    rv_next = 1'b1;
                    state_next = mpi_pkg::ST_IDLE;
                end
                else if (first_reg == '0)
                begin
                    // below the first entry
                    key_next   = rd_map_x + $signed({10'b0, end_window});
                    right_next = 1'b0;
                    len_next   = count_reg;
                    state_next = mpi_pkg::ST_MSRCH;
                end
                else
                begin
                    ia_next = AW'(first_reg - CW'(1));
                    ib_next = first_reg[AW-1:0];
                    state_next = mpi_pkg::ST_RDA;
                end
            end
            mpi_pkg::ST_KEY:
            begin
                key_next   = rd_map_x - $signed({10'b0, end_window});
                right_next = 1'b1;
                first_next = '0;
                len_next   = count_reg;
                state_next = mpi_pkg::ST_MSRCH;
            end
            mpi_pkg::ST_MSRCH:
            begin
                if (len_reg == '0)
                begin
                    if (right_reg)
                    begin
                        ia_next = (first_reg >= count_reg) ? last[AW-1:0] : first_reg[AW-1:0];
                        ib_next = last[AW-1:0];
                    end
                    else
                    begin
                        ia_next = '0;
                        ib_next = (first_reg < last) ? first_reg[AW-1:0] : last[AW-1:0];
                    end
                    state_next = mpi_pkg::ST_RDA;
                end
                else
                begin
                    state_next = mpi_pkg::ST_MCMP;
                end
            end
            mpi_pkg::ST_MCMP:
            begin
                if (rd_map_x < key_reg)
                begin
                    first_next = mid + CW'(1);
                    len_next   = len_reg - half - CW'(1);
                end
                else
                begin
                    len_next = half;
                end
                state_next = mpi_pkg::ST_MSRCH;
            end
            mpi_pkg::ST_RDA:
            begin
                raddr = ia_reg;
                state_next = mpi_pkg::ST_RDB;
            end
            mpi_pkg::ST_RDB:
            begin
                raddr   = ib_reg;
                a_next  = rd_phys;
                fa_next = rd_map;
                state_next = mpi_pkg::ST_CALC;
            end
            mpi_pkg::ST_CALC:
            begin
                if (rd_phys == a_reg)
                begin
                    res_next.gen_pos = fa_reg;
                    res_next.status  = mpi_pkg::STATUS_DEGEN;
                    rv_next = 1'b1;
                    state_next = mpi_pkg::ST_IDLE;
                end
                else
                begin
                    dx_next  = dx_s[31] ? dx_neg[30:0] : dx_s[30:0];
                    db_next  = db_s[31] ? db_neg[30:0] : db_s[30:0];
                    dy_next  = dy_s[32] ? dy_neg[31:0] : dy_s[31:0];
                    neg_next = dx_s[31] ^ db_s[31] ^ dy_s[32];
                    state_next = mpi_pkg::ST_MUL0;
                end
            end
            mpi_pkg::ST_MUL0:
            begin
                prod_next  = {17'b0, p0};
                state_next = mpi_pkg::ST_MUL1;
            end
            mpi_pkg::ST_MUL1:
            begin
                prod_next  = prod_reg + {1'b0, p1, 16'b0};
                state_next = mpi_pkg::ST_DGO;
            end
            mpi_pkg::ST_DGO:
            begin
                div_start  = 1'b1;
                state_next = mpi_pkg::ST_DWAIT;
            end
            mpi_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    if (sum > 42'sd2147483647)
                    begin
                        res_next.gen_pos = 32'sh7FFF_FFFF;
                    end
                    else if (sum < -42'sd2147483648)
                    begin
                        res_next.gen_pos = 32'sh8000_0000;
                    end
                    else
                    begin
                        res_next.gen_pos = sum[31:0];
                    end
                    res_next.status = mpi_pkg::STATUS_OK;
                    rv_next = 1'b1;
                    state_next = mpi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpi_pkg::ST_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        len_reg   <= len_next;
        site_reg  <= site_next;
        key_reg   <= key_next;
        right_reg <= right_next;
        ia_reg    <= ia_next;
        ib_reg    <= ib_next;
        a_reg     <= a_next;
        fa_reg    <= fa_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        db_reg    <= db_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = rv_reg;

endmodule

// ----- sv/map_position_interpolator.sv -----
// ----------------------------------------------------------------------------
// map_position_interpolator
// Piecewise linear map position lookup over an appended breakpoint table.
// ----------------------------------------------------------------------------
// Items enter through a two-entry queue; busy is high only while it is full.
// Appends, clears and unused modes are handled without leaving the idle state.
// A query runs one or two binary searches (each probe goes through the
// registered table read), then table reads, the multiply states ST_MUL0 and
// ST_MUL1 and the bit-serial divider. Empty tables are answered without a
// search, exact hits right after the position search, and degenerate
// segments right after the segment reads, all without multiply or divide. The
// result is shown for one cycle with result_valid and cannot be held off.
module map_position_interpolator #(
    parameter int MAP_DEPTH = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  mpi_pkg::cmd_t cmd,
    output mpi_pkg::res_t result,
    output logic          result_valid,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [23:0]   cfg_data
);

    logic [23:0]     window_reg, window_next;
    mpi_pkg::qhead_t head;
    logic            pop;

    assign cfg_ready   = 1'b1;
    assign window_next = (cfg_valid && cfg_ready) ? cfg_data : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= mpi_pkg::WINDOW_RESET;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    mpi_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    mpi_back #(.MAP_DEPTH(MAP_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .end_window   (window_reg),
        .head         (head),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ----- test/tb_map_position_interpolator.sv -----
// ----------------------------------------------------------------------------
// tb_map_position_interpolator
// Self-checking bench for the map position interpolator: builds breakpoint
// tables, runs lookups inside, on and beyond the table under several end
// window settings, and compares every lookup against a local model.
// ----------------------------------------------------------------------------
class interp_scoreboard;

    localparam int DEPTH = 1024;
    localparam longint QUOT_CLAMP = 64'sd1 << 40;

    logic [30:0]        phys_tab [DEPTH];
    logic signed [31:0] map_tab  [DEPTH];
    int                 entries;
    logic [23:0]        window;
    mpi_pkg::res_t      pending [$];
    int                 errors;
    int                 lookups;
    int                 hits;
    int                 degens;
    int                 empties;
    int                 saturated;

    function new();
        entries = 0;
        window = mpi_pkg::WINDOW_RESET;
        errors = 0;
        lookups = 0;
        hits = 0;
        degens = 0;
        empties = 0;
        saturated = 0;
    endfunction

    function int lower_phys(int n, logic [30:0] key);
        int first;
        int len;
        int half;
        first = 0;
        len = n;
        while (len > 0)
        begin
            half = len / 2;
            if (phys_tab[first + half] < key)
            begin
                first += half + 1;
                len -= half + 1;
            end
            else
                len = half;
        end
        return first;
    endfunction

    function int lower_map(int n, longint key);
        int first;
        int len;
        int half;
        first = 0;
        len = n;
        while (len > 0)
        begin
            half = len / 2;
            if (longint'(map_tab[first + half]) < key)
            begin
                first += half + 1;
                len -= half + 1;
            end
            else
                len = half;
        end
        return first;
    endfunction

    function mpi_pkg::res_t predict_lookup(logic [30:0] site);
        mpi_pkg::res_t r;
        int     idx;
        int     ia;
        int     ib;
        int     g;
        longint a;
        longint b;
        longint fa;
        longint fb;
        longint q;
        longint sum;
        r.gen_pos = '0;
        r.status = mpi_pkg::STATUS_OK;
        if (entries == 0)
        begin
            r.status = mpi_pkg::STATUS_EMPTY;
            empties++;
            return r;
        end
        idx = lower_phys(entries, site);
        if (idx < entries && phys_tab[idx] == site)
        begin
            r.gen_pos = map_tab[idx];
            hits++;
            return r;
        end
        if (idx == entries)
        begin
            ia = lower_map(entries, longint'(map_tab[entries - 1]) - longint'(window));
            ib = entries - 1;
        end
        else if (idx == 0)
        begin
            g = lower_map(entries, longint'(map_tab[0]) + longint'(window));
            ia = 0;
            ib = (g < entries - 1) ? g : entries - 1;
        end
        else
        begin
            ia = idx - 1;
            ib = idx;
        end
        if (ia >= entries)
            ia = entries - 1;
        a = longint'(phys_tab[ia]);
        b = longint'(phys_tab[ib]);
        fa = longint'(map_tab[ia]);
        fb = longint'(map_tab[ib]);
        if (a == b)
        begin
            r.gen_pos = fa[31:0];
            r.status = mpi_pkg::STATUS_DEGEN;
            degens++;
            return r;
        end
        // truncating divide, quotient clamp, then 32-bit saturation
        q = ((longint'(site) - a) * (fb - fa)) / (b - a);
        if (q > QUOT_CLAMP)
            q = QUOT_CLAMP;
        if (q < -QUOT_CLAMP)
            q = -QUOT_CLAMP;
        sum = fa + q;
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            saturated++;
        end
        if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            saturated++;
        end
        r.gen_pos = sum[31:0];
        return r;
    endfunction

    function void note_item(mpi_pkg::cmd_t c);
        case (c.mode)
            mpi_pkg::MODE_APPEND:
            begin
                if (entries < DEPTH)
                begin
                    phys_tab[entries] = c.phys_pos;
                    map_tab[entries] = c.map_value;
                    entries++;
                end
            end
            mpi_pkg::MODE_QUERY:
            begin
                lookups++;
                pending.insert(pending.size(), predict_lookup(c.phys_pos));
            end
            mpi_pkg::MODE_CLEAR:
                entries = 0;
            default:
                ;
        endcase
    endfunction

    function void check_result(mpi_pkg::res_t got);
        mpi_pkg::res_t exp_r;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result gen_pos=%0d status=%0d",
                     $time, got.gen_pos, got.status);
            return;
        end
        exp_r = pending.pop_front();
        if (got.gen_pos !== exp_r.gen_pos)
        begin
            errors++;
            $display("%0t: gen_pos mismatch expected %0d actual %0d",
                     $time, exp_r.gen_pos, got.gen_pos);
        end
        if (got.status !== exp_r.status)
        begin
            errors++;
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, exp_r.status, got.status);
        end
    endfunction
endclass

module tb_map_position_interpolator;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE = 400;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    mpi_pkg::cmd_t cmd;
    mpi_pkg::res_t result;
    logic          result_valid;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [23:0]   cfg_data;

    interp_scoreboard sb;
    int cycles = 0;
    int burst_left;
    int item_total;
    int window_writes;

    map_position_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_map_position_interpolator: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    task automatic send_item(logic [1:0] m, logic [30:0] p, logic signed [31:0] v);
        mpi_pkg::cmd_t c;
        int gap;
        c.mode = m;
        c.phys_pos = p;
        c.map_value = v;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (busy);
        sb.note_item(c);
        item_total++;
    endtask

    task automatic set_window(logic [23:0] w);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        // trailing appends or clears may still be in flight
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.window = w;
        window_writes++;
    endtask

    // clear, then a sorted table from n appends, map values non-decreasing with a random step
    task automatic build_table(int n, int step_max);
        logic [30:0]        p;
        logic signed [31:0] v;
        int i;
        p = 31'($urandom_range(0, 1000));
        v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        send_item(mpi_pkg::MODE_CLEAR, 31'($urandom), $urandom);
        for (i = 0; i < n; i++)
        begin
            send_item(mpi_pkg::MODE_APPEND, p, v);
            p = p + 31'($urandom_range(1, step_max));
            v = v + $signed($urandom_range(0, 32'h0003_0000));
        end
    endtask

    task automatic random_phase(int count);
        int i;
        int sel;
        logic [30:0] p;
        for (i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
                build_table($urandom_range(1, 24), $urandom_range(2, 5000));
            else if (sel < 7)
                send_item(mpi_pkg::MODE_APPEND, 31'($urandom), $urandom);
            else if (sel < 9)
                send_item(mpi_pkg::MODE_UNUSED, 31'($urandom), $urandom);
            else if (sel < 10)
                send_item(mpi_pkg::MODE_CLEAR, 31'($urandom), $urandom);
            else
            begin
                if (sb.entries > 0 && $urandom_range(0, 3) != 0)
                begin
                    p = sb.phys_tab[$urandom_range(0, sb.entries - 1)];
                    if ($urandom_range(0, 2) != 0)
                        p = p + 31'($urandom_range(0, 3000)) - 31'd1500;
                end
                else
                    p = 31'($urandom);
                send_item(mpi_pkg::MODE_QUERY, p, $urandom);
            end
        end
    endtask

    initial
    begin
        int i;
        sb = new();
        burst_left = 0;
        item_total = 0;
        window_writes = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, unused mode, field extremes
        send_item(mpi_pkg::MODE_QUERY, 31'h7FFF_FFFF, 32'sh0);
        send_item(mpi_pkg::MODE_UNUSED, 31'h7FFF_FFFF, 32'shFFFF_FFFF);
        send_item(mpi_pkg::MODE_APPEND, 31'd0, 32'sh8000_0000);
        send_item(mpi_pkg::MODE_APPEND, 31'd100, 32'sh0001_0000);
        send_item(mpi_pkg::MODE_APPEND, 31'd100, 32'sh0002_0000);
        send_item(mpi_pkg::MODE_APPEND, 31'd300, 32'sh0006_0000);
        send_item(mpi_pkg::MODE_APPEND, 31'h7FFF_FFFE, 32'sh7FFF_FFFF);
        send_item(mpi_pkg::MODE_QUERY, 31'd0, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'd100, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'd200, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'd50, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'h7FFF_FFFF, 32'sh0);
        send_item(mpi_pkg::MODE_CLEAR, 31'd0, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'd5, 32'sh0);
        // steep end segment to push extrapolation into saturation
        send_item(mpi_pkg::MODE_APPEND, 31'd1000, 32'sh0);
        send_item(mpi_pkg::MODE_APPEND, 31'd1001, 32'sh7000_0000);
        send_item(mpi_pkg::MODE_QUERY, 31'h7FFF_FFFF, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'd0, 32'sh0);
        // degenerate pair
        send_item(mpi_pkg::MODE_CLEAR, 31'd0, 32'sh0);
        send_item(mpi_pkg::MODE_APPEND, 31'd40, 32'sh0001_0000);
        send_item(mpi_pkg::MODE_APPEND, 31'd40, 32'sh0009_0000);
        send_item(mpi_pkg::MODE_QUERY, 31'd10, 32'sh0);
        send_item(mpi_pkg::MODE_QUERY, 31'd90, 32'sh0);

        set_window(24'd0);
        random_phase(12);
        set_window(24'hFF_FFFF);
        random_phase(12);

        // full table plus appends past capacity
        build_table(1026, 3);
        for (i = 0; i < 20; i++)
            send_item(mpi_pkg::MODE_QUERY, 31'($urandom_range(0, 4000)), $urandom);

        set_window(24'h01_0000);
        random_phase(12);
        set_window(24'($urandom_range(0, 24'hFF_FFFF)));
        random_phase(12);
        set_window(mpi_pkg::WINDOW_RESET);
        random_phase(12);

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d items, %0d lookups (%0d exact, %0d degenerate, %0d empty)",
                 item_total, sb.lookups, sb.hits, sb.degens, sb.empties);
        $display("%0d saturated lookups, %0d end window writes",
                 sb.saturated, window_writes);
        if (sb.errors == 0)
            $display("tb_map_position_interpolator: done, clean");
        else
            $display("tb_map_position_interpolator: done, errors");
        $finish;
    end
endmodule

// ----- map_position_interpolator.f -----
sv/mpi_pkg.sv
sv/mpi_ram.sv
sv/mpi_div.sv
sv/mpi_front.sv
sv/mpi_back.sv
sv/map_position_interpolator.sv
test/tb_map_position_interpolator.sv
